### rtl/psa_pkg.sv
// shared constants and widths for the partitioned slot allocator
`timescale 1ns / 1ps
package psa_pkg;

  localparam int TOTAL_SLOTS = 32;
  localparam int KEY_CHARS   = 8;

  localparam int KEY_W    = 64;
  localparam int CFG_W    = 6;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_CNT_W = 6;

  localparam int SLOT_W = $clog2(TOTAL_SLOTS);
  localparam int CNT_W  = $clog2(TOTAL_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic ACT_ASSIGN  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

### rtl/psa_key_fold.sv
// key folding: truncate at first zero byte or char limit, lower case to upper case
`timescale 1ns / 1ps
module psa_key_fold (
  input  logic [psa_pkg::KEY_W-1:0] key_raw,
  output logic [psa_pkg::KEY_W-1:0] key_folded
);

  always_comb begin
    logic       live;
    logic [7:0] b;
    live = 1'b1;
    key_folded = '0;
    for (int i = 0; i < 8; i++) begin
      b = key_raw[8*i +: 8];
      if (i >= psa_pkg::KEY_CHARS || b == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        if (b >= 8'h61 && b <= 8'h7a) begin
          b = b - 8'h20;
        end
        key_folded[8*i +: 8] = b;
      end
    end
  end

endmodule

### rtl/psa_key_ram.sv
// stored key memory, one write port and one registered read port
`timescale 1ns / 1ps
module psa_key_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [psa_pkg::SLOT_W-1:0] waddr,
  input  logic [psa_pkg::KEY_W-1:0]  wdata,
  input  logic                       re,
  input  logic [psa_pkg::SLOT_W-1:0] raddr,
  output logic [psa_pkg::KEY_W-1:0]  rdata
);

  logic [psa_pkg::KEY_W-1:0] mem [psa_pkg::TOTAL_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/partitioned_slot_allocator_core.sv
// top level: slot allocator with scan sequencer over the key memory
`timescale 1ns / 1ps
// Slot allocator with two classes split at class0_slots. Each item scans the
// whole table once through the key memory, one slot per cycle, paced by the
// single read port of the key memory. A new item is taken only once the scan
// of the previous one is finished and its result is registered for the output.
// A new item is accepted while the previous result waits on the output, and
// that item's result then waits until the output is free. Occupancy flags sit
// in flip-flops and clear at reset; stored keys are never cleared.
module partitioned_slot_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic                          vehicle_class,
  input  logic [psa_pkg::KEY_W-1:0]     key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psa_pkg::OUT_IDX_W-1:0] slot_index,
  output logic                          success,
  output logic [psa_pkg::OUT_CNT_W-1:0] free_count
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t                            state;
  logic [psa_pkg::CFG_W-1:0]         class0_slots;
  logic [psa_pkg::TOTAL_SLOTS-1:0]   occ;
  logic [psa_pkg::KEY_W-1:0]         key_folded;
  logic [psa_pkg::KEY_W-1:0]         req_key;
  logic                              req_act;
  logic [psa_pkg::CMP_W-1:0]         req_lo;
  logic [psa_pkg::CMP_W-1:0]         req_hi;
  logic [psa_pkg::CNT_W-1:0]         ptr;
  logic                              chk_valid;
  logic [psa_pkg::SLOT_W-1:0]        chk_idx;
  logic                              found;
  logic [psa_pkg::SLOT_W-1:0]        hit_idx;
  logic                              hit_in_range;
  logic [psa_pkg::CNT_W-1:0]         free_cnt;
  logic [psa_pkg::KEY_W-1:0]         rdata;
  logic [psa_pkg::CMP_W-1:0]         bnd;
  logic                              scan_issue;
  logic                              chk_in_range;
  logic                              chk_free;
  logic                              chk_match;
  logic                              ram_we;
  logic [psa_pkg::CNT_W-1:0]         cnt_final;

  psa_key_fold u_fold (
    .key_raw    (key),
    .key_folded (key_folded)
  );

  psa_key_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx),
    .wdata (req_key),
    .re    (scan_issue),
    .raddr (ptr[psa_pkg::SLOT_W-1:0]),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign bnd = (psa_pkg::CMP_W'(class0_slots) > psa_pkg::CMP_W'(psa_pkg::TOTAL_SLOTS)) ?
               psa_pkg::CMP_W'(psa_pkg::TOTAL_SLOTS) : psa_pkg::CMP_W'(class0_slots);

  assign scan_issue   = (state == ST_SCAN) && (ptr != psa_pkg::CNT_W'(psa_pkg::TOTAL_SLOTS));
  assign chk_in_range = (psa_pkg::CMP_W'(chk_idx) >= req_lo) &&
                        (psa_pkg::CMP_W'(chk_idx) < req_hi);
  assign chk_free     = !occ[chk_idx];
  assign chk_match    = !chk_free && (rdata == req_key);
  assign ram_we       = (state == ST_FINISH) && (!out_valid || out_ready) && found &&
                        (req_act == psa_pkg::ACT_ASSIGN);

  always_comb begin
    cnt_final = free_cnt;
    if (found) begin
      if (req_act == psa_pkg::ACT_ASSIGN) begin
        cnt_final = free_cnt - 1'b1;
      end else if (hit_in_range) begin
        cnt_final = free_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      class0_slots <= psa_pkg::CFG_W'(20);
      occ          <= '0;
      out_valid    <= 1'b0;
      chk_valid    <= 1'b0;
      found        <= 1'b0;
      ptr          <= '0;
    end else begin
      if (cfg_valid) begin
        class0_slots <= cfg_data;
      end
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_key   <= key_folded;
            req_act   <= action;
            req_lo    <= vehicle_class ? bnd : '0;
            req_hi    <= vehicle_class ? psa_pkg::CMP_W'(psa_pkg::TOTAL_SLOTS) : bnd;
            ptr       <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            free_cnt  <= '0;
            hit_idx   <= '0;
            hit_in_range <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_valid <= scan_issue;
          chk_idx   <= ptr[psa_pkg::SLOT_W-1:0];
          if (scan_issue) begin
            ptr <= ptr + 1'b1;
          end
          if (chk_valid) begin
            if (chk_in_range && chk_free) begin
              free_cnt <= free_cnt + 1'b1;
            end
            if (!found) begin
              if ((req_act == psa_pkg::ACT_ASSIGN && chk_in_range && chk_free) ||
                  (req_act == psa_pkg::ACT_RELEASE && chk_match)) begin
                found        <= 1'b1;
                hit_idx      <= chk_idx;
                hit_in_range <= chk_in_range;
              end
            end
          end else if (!scan_issue) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            success    <= found;
            slot_index <= found ? psa_pkg::OUT_IDX_W'(hit_idx) : '0;
            free_count <= psa_pkg::OUT_CNT_W'(cnt_final);
            if (found) begin
              occ[hit_idx] <= (req_act == psa_pkg::ACT_ASSIGN);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for partitioned_slot_allocator_core
module tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 236;
  localparam int POOL_SIZE     = 16;
  localparam int CLASS0_RESET  = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic [psa_pkg::OUT_IDX_W-1:0] slot;
    logic                          ok;
    logic [psa_pkg::OUT_CNT_W-1:0] free;
  } grant_t;

  class slot_alloc_checker;
    logic [psa_pkg::CFG_W-1:0] boundary;
    bit                        busy [psa_pkg::TOTAL_SLOTS];
    logic [psa_pkg::KEY_W-1:0] ids  [psa_pkg::TOTAL_SLOTS];
    grant_t                    pending_grants[$];
    int                        errors;
    int                        n_results;
    int                        n_refused;

    function new();
      boundary = psa_pkg::CFG_W'(CLASS0_RESET);
      for (int i = 0; i < psa_pkg::TOTAL_SLOTS; i++) begin
        busy[i] = 1'b0;
        ids[i]  = '0;
      end
      errors    = 0;
      n_results = 0;
      n_refused = 0;
    endfunction

    // key ends at first zero byte, lower case letters fold to upper
    static function logic [psa_pkg::KEY_W-1:0] fold_id(logic [psa_pkg::KEY_W-1:0] raw);
      logic [psa_pkg::KEY_W-1:0] r;
      logic [7:0]                ch;
      bit                        ended;
      r     = '0;
      ended = 1'b0;
      for (int i = 0; i < psa_pkg::KEY_CHARS; i++) begin
        ch = raw[8*i +: 8];
        if (ch == 8'h00) ended = 1'b1;
        if (!ended) begin
          if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
          r[8*i +: 8] = ch;
        end
      end
      return r;
    endfunction

    function void note_request(logic act, logic cls, logic [psa_pkg::KEY_W-1:0] raw);
      logic [psa_pkg::KEY_W-1:0] k;
      grant_t                    g;
      int                        lim;
      int                        lo;
      int                        hi;
      int                        cnt;
      k   = fold_id(raw);
      lim = (int'(boundary) > psa_pkg::TOTAL_SLOTS) ? psa_pkg::TOTAL_SLOTS : int'(boundary);
      lo  = cls ? lim : 0;
      hi  = cls ? psa_pkg::TOTAL_SLOTS : lim;
      g   = '0;
      if (act == psa_pkg::ACT_ASSIGN) begin
        for (int i = lo; i < hi; i++) begin
          if (!busy[i]) begin
            busy[i] = 1'b1;
            ids[i]  = k;
            g.slot  = psa_pkg::OUT_IDX_W'(i);
            g.ok    = 1'b1;
            break;
          end
        end
      end else begin
        for (int i = 0; i < psa_pkg::TOTAL_SLOTS; i++) begin
          if (busy[i] && ids[i] == k) begin
            busy[i] = 1'b0;
            ids[i]  = '0;
            g.slot  = psa_pkg::OUT_IDX_W'(i);
            g.ok    = 1'b1;
            break;
          end
        end
      end
      cnt = 0;
      for (int i = lo; i < hi; i++) if (!busy[i]) cnt++;
      g.free = psa_pkg::OUT_CNT_W'(cnt);
      pending_grants.push_back(g);
    endfunction

    function void check_grant(logic [psa_pkg::OUT_IDX_W-1:0] slot, logic ok,
                              logic [psa_pkg::OUT_CNT_W-1:0] free);
      grant_t e;
      n_results++;
      if (pending_grants.size() == 0) begin
        $error("result with no request waiting: slot_index %0d success %0d free_count %0d",
               slot, ok, free);
        errors++;
        return;
      end
      e = pending_grants.pop_front();
      if (!e.ok) n_refused++;
      if (slot !== e.slot) begin
        $error("slot_index expected %0d actual %0d", e.slot, slot);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("success expected %0d actual %0d", e.ok, ok);
        errors++;
      end
      if (free !== e.free) begin
        $error("free_count expected %0d actual %0d", e.free, free);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [psa_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          action;
  logic                          vehicle_class;
  logic [psa_pkg::KEY_W-1:0]     key;
  logic                          out_valid;
  logic                          out_ready;
  logic [psa_pkg::OUT_IDX_W-1:0] slot_index;
  logic                          success;
  logic [psa_pkg::OUT_CNT_W-1:0] free_count;

  slot_alloc_checker         sb = new();
  int                        send_idle_pct  = 0;
  int                        recv_stall_pct = 0;
  int                        cycles         = 0;
  int                        n_requests     = 0;
  logic [psa_pkg::KEY_W-1:0] id_pool [POOL_SIZE];
  logic [psa_pkg::KEY_W-1:0] strays[$];

  partitioned_slot_allocator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .vehicle_class (vehicle_class),
    .key           (key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_index    (slot_index),
    .success       (success),
    .free_count    (free_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (recv_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.boundary = cfg_data;
      if (in_valid && in_ready) begin
        sb.note_request(action, vehicle_class, key);
        n_requests++;
      end
      if (out_valid && out_ready) sb.check_grant(slot_index, success, free_count);
    end
  end

  function automatic logic [psa_pkg::KEY_W-1:0] make_id();
    logic [psa_pkg::KEY_W-1:0] r;
    logic [7:0]                ch;
    int                        len;
    r   = '0;
    len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, psa_pkg::KEY_CHARS);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0:       ch = "A" + 8'($urandom_range(0, 25));
        1:       ch = "a" + 8'($urandom_range(0, 25));
        2:       ch = "0" + 8'($urandom_range(0, 9));
        default: ch = 8'($urandom_range(1, 255));
      endcase
      r[8*i +: 8] = ch;
    end
    return slot_alloc_checker::fold_id(r);
  endfunction

  // same folded key, random letter case and optional junk after the terminator
  function automatic logic [psa_pkg::KEY_W-1:0] disguise_id(logic [psa_pkg::KEY_W-1:0] canon);
    logic [psa_pkg::KEY_W-1:0] r;
    logic [7:0]                ch;
    bit                        ended;
    bit                        junk;
    r     = '0;
    ended = 1'b0;
    junk  = $urandom_range(0, 1);
    for (int i = 0; i < psa_pkg::KEY_CHARS; i++) begin
      ch = canon[8*i +: 8];
      if (ended) ch = junk ? 8'($urandom_range(0, 255)) : 8'h00;
      else if (ch == 8'h00) ended = 1'b1;
      else if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) ch = ch + 8'd32;
      r[8*i +: 8] = ch;
    end
    return r;
  endfunction

  task automatic write_boundary(input logic [psa_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic a, input logic c,
                              input logic [psa_pkg::KEY_W-1:0] k);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= a;
    vehicle_class <= c;
    key           <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_all_granted(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  initial begin
    logic [psa_pkg::CFG_W-1:0] phase_cfg [NUM_PHASES];
    logic [psa_pkg::KEY_W-1:0] k;
    int                        pick;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    action        <= psa_pkg::ACT_ASSIGN;
    vehicle_class <= 1'b0;
    key           <= '0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = make_id();
    phase_cfg = '{6'd0, 6'd63, 6'd32, 6'd20, 6'd1, 6'd31,
                  psa_pkg::CFG_W'($urandom_range(2, 30)), 6'd33};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two slot class 0 to reach full and empty quickly
    write_boundary(6'd2);
    send_request(psa_pkg::ACT_ASSIGN,  1'b0, 64'h0000_0000_0000_6261);
    send_request(psa_pkg::ACT_ASSIGN,  1'b0, 64'h0000_0000_0000_0000);
    send_request(psa_pkg::ACT_ASSIGN,  1'b0, 64'h0000_0000_0000_5A5A);
    send_request(psa_pkg::ACT_ASSIGN,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(psa_pkg::ACT_ASSIGN,  1'b1, 64'hDEAD_BEEF_FF00_4241);
    send_request(psa_pkg::ACT_RELEASE, 1'b0, 64'h0000_0000_0000_4241);
    send_request(psa_pkg::ACT_RELEASE, 1'b1, 64'h1234_5678_9A00_6241);
    send_request(psa_pkg::ACT_RELEASE, 1'b0, 64'h0000_0000_0000_0000);
    send_request(psa_pkg::ACT_RELEASE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(psa_pkg::ACT_RELEASE, 1'b1, 64'h0000_0000_0000_4241);
    send_request(psa_pkg::ACT_RELEASE, 1'b0, 64'h0000_0000_0000_0000);
    send_request(psa_pkg::ACT_ASSIGN,  1'b1, 64'hE180_405B_607B_617A);
    send_request(psa_pkg::ACT_RELEASE, 1'b1, 64'hE180_405B_607B_415A);
    wait_all_granted(4);
    // empty class 0
    write_boundary(6'd0);
    send_request(psa_pkg::ACT_ASSIGN,  1'b0, 64'h0000_0000_0000_0078);
    send_request(psa_pkg::ACT_ASSIGN,  1'b1, 64'h0000_0000_0000_0078);
    wait_all_granted(4);
    // boundary past the table, class 1 empty
    write_boundary(6'd63);
    send_request(psa_pkg::ACT_ASSIGN,  1'b1, 64'h0000_0000_0000_0079);
    send_request(psa_pkg::ACT_ASSIGN,  1'b0, 64'h0000_0000_0000_0079);
    send_request(psa_pkg::ACT_RELEASE, 1'b1, 64'h0000_0000_0000_0058);
    send_request(psa_pkg::ACT_RELEASE, 1'b0, 64'h0000_0000_0000_0059);
    wait_all_granted(4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_boundary(phase_cfg[p]);
      set_pacing(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 44) begin
          send_request(psa_pkg::ACT_ASSIGN, 1'($urandom_range(0, 1)),
                       disguise_id(id_pool[$urandom_range(0, POOL_SIZE - 1)]));
        end else if (pick < 86) begin
          if (strays.size() != 0 && $urandom_range(0, 3) == 0) k = strays.pop_front();
          else k = disguise_id(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
          send_request(psa_pkg::ACT_RELEASE, 1'($urandom_range(0, 1)), k);
        end else begin
          k = {$urandom, $urandom};
          if ($urandom_range(0, 1)) begin
            strays.push_back(k);
            send_request(psa_pkg::ACT_ASSIGN, 1'($urandom_range(0, 1)), k);
          end else begin
            send_request(psa_pkg::ACT_RELEASE, 1'($urandom_range(0, 1)), k);
          end
        end
      end
      wait_all_granted(4);
    end

    set_pacing(0);
    wait_all_granted(SETTLE_CYCLES);
    $display("summary: %0d requests over %0d random boundary phases and four pacing modes",
             n_requests, NUM_PHASES);
    $display("summary: %0d results checked, %0d refused, %0d mismatches",
             sb.n_results, sb.n_refused, sb.errors);
    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/psa_pkg.sv
rtl/psa_key_fold.sv
rtl/psa_key_ram.sv
rtl/partitioned_slot_allocator_core.sv
tb/tb.sv
